### rtl/core/polar_gaussian_sample_generator_defines.svh
// Assertion macros shared by the generator's RTL.
// Both sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef POLAR_GAUSSIAN_SAMPLE_GENERATOR_DEFINES_SVH
`define POLAR_GAUSSIAN_SAMPLE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pgsg_pkg.sv
package pgsg_pkg;

  // Default width of one uniform input value.
  localparam int UNIFORM_BITS_DEF = 16;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_OFFSET,
    CFG_STD_SCALE
  } cfg_idx_e;

  // Result and register widths.
  localparam int SAMPLE_W = 32;
  localparam int SCALE_W  = 16;

  localparam logic [SCALE_W-1:0] STD_SCALE_RESET = 16'd12953;

  // Logarithm: Q.30 mantissa, 24 fraction bits of log2.
  localparam int XF         = 30;
  localparam int XW         = XF + 1;
  localparam int LOG_ROUNDS = 24;

  // 2 ln 2 in Q.30.
  localparam int                LN2_W       = 31;
  localparam logic [LN2_W-1:0]  TWO_LN2_Q30 = 31'd1488522236;

  // Ratio u^2 / W carries 62 fraction bits.
  localparam int DIV_FRAC = 62;

  // Final rounding shifts.
  localparam int D_SHIFT = 30;
  localparam int S_SHIFT = 24;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  // Control bits that travel with an item.
  typedef struct packed {
    logic valid;
    logic ok;
    logic neg_a;
    logic neg_b;
  } side_t;

endpackage

### rtl/core/pgsg_intf.sv
// Input channel: one pair of signed uniform values per beat.
interface pgsg_in_if import pgsg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [UNIFORM_BITS-1:0] uniform_first;
  logic signed [UNIFORM_BITS-1:0] uniform_second;

  modport source (output valid, output uniform_first, output uniform_second, input ready);
  modport sink   (input valid, input uniform_first, input uniform_second, output ready);
endinterface

// Output channel: one Gaussian sample per beat.
interface pgsg_out_if import pgsg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] normal_sample;
  logic                       last_of_pair;
  logic                       clipped;

  modport source (output valid, output normal_sample, output last_of_pair,
                  output clipped, input ready);
  modport sink   (input valid, input normal_sample, input last_of_pair,
                  input clipped, output ready);
endinterface

### rtl/core/pgsg_isqrt_pipe.sv
// Pipelined integer square root: one root bit per stage, RW stages.
module pgsg_isqrt_pipe #(
  parameter int RW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (j == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_body
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem2  = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[RW:0] : rem2[RW:0];
        root_q[j] <= {root_in[RW-2:0], ge};
        rad_q[j]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

### rtl/core/polar_gaussian_sample_generator.sv
// Marsaglia polar Gaussian generator. Each input beat carries two signed uniform
// values; pairs with W = u1^2 + u2^2 outside (0,1) are dropped, and every other
// pair gives two output beats, mean + scale*u*sqrt(-2 ln W / W) for the first and
// then the second value, the second marked last_of_pair. The datapath is one
// pipeline that advances as a whole, with a bit-serial divider (63 stages) and a
// square root (32 stages) per value dominating its length. An input beat can be
// taken in every cycle while the pair buffer does not stall the pipeline, but the
// two samples of a pair share the single output port, so a steady stream of
// accepted pairs is held back by the output; dropped pairs cost no output slot.
// Configuration writes must only be made while the pipeline is empty.
module polar_gaussian_sample_generator import pgsg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  pgsg_in_if.sink              in_i,
  pgsg_out_if.source           out_o
);

  `include "polar_gaussian_sample_generator_defines.svh"

  localparam int UB     = UNIFORM_BITS;
  localparam int WW     = 2 * UB;
  localparam int LZB    = $clog2(WW);
  localparam int LW     = LZB + LOG_ROUNDS;
  localparam int PW     = LW + LN2_W;
  localparam int GW     = (PW + 1) / 2;
  localparam int QW     = DIV_FRAC + 1;
  localparam int CW     = (QW + 1) / 2;
  localparam int DPW    = CW + GW + 1;
  localparam int DW     = DPW - D_SHIFT;
  localparam int EPW    = DW + SCALE_W + 1;
  localparam int DEVW   = EPW - S_SHIFT;
  localparam int SUMW   = ((DEVW + 1 > SAMPLE_W) ? DEVW + 1 : SAMPLE_W) + 1;
  localparam int GDLY   = (QW + CW) - (LZB + LOG_ROUNDS + 2 + GW);

  localparam logic [DPW-1:0] D_RND = DPW'(1) << (D_SHIFT - 1);
  localparam logic [EPW-1:0] E_RND = EPW'(1) << (S_SHIFT - 1);

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] mean_q;
  logic [SCALE_W-1:0]         scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      scale_q <= STD_SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MEAN_OFFSET: mean_q  <= signed'(cfg_wdata_i[SAMPLE_W-1:0]);
        CFG_STD_SCALE:   scale_q <= cfg_wdata_i[SCALE_W-1:0];
        default:         ;
      endcase
    end
  end

  // Whole-pipeline advance, driven by the output pair buffer.
  logic adv;

  // Stage 0: sign and magnitude of each value.
  logic          v0_q;
  logic [1:0]    neg0_q;
  logic [UB-1:0] mag0_q [2];
  logic [UB-1:0] raw    [2];

  assign raw[0] = in_i.uniform_first;
  assign raw[1] = in_i.uniform_second;

  // Stage 1: squares. Stage 2: W and the range check.
  logic          v1_q;
  logic [1:0]    neg1_q;
  logic [WW-1:0] sq1_q [2];
  side_t         sd2_q;
  side_t         sd2_d;
  logic [WW-1:0] w2_q;
  logic [WW-1:0] w2_d;
  logic [WW-1:0] num2_q [2];

  assign w2_d        = sq1_q[0] + sq1_q[1];
  assign sd2_d.valid = v1_q;
  assign sd2_d.ok    = (w2_d != '0) && (w2_d[WW-1 -: 2] == 2'b00);
  assign sd2_d.neg_a = neg1_q[0];
  assign sd2_d.neg_b = neg1_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      sd2_q <= '0;
    end else if (adv) begin
      v0_q  <= in_i.valid;
      v1_q  <= v0_q;
      sd2_q <= sd2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        neg0_q[l] <= raw[l][UB-1];
        mag0_q[l] <= raw[l][UB-1] ? (~raw[l] + 1'b1) : raw[l];
        sq1_q[l]  <= mag0_q[l] * mag0_q[l];
        num2_q[l] <= sq1_q[l];
      end
      neg1_q <= neg0_q;
      w2_q   <= w2_d;
    end
  end

  // Restoring division u^2 / W, one quotient bit per stage and value.
  side_t         dv_q [QW];
  logic [WW-1:0] dw_q [QW];
  logic [WW-1:0] dr_q [2][QW];
  logic [QW-1:0] dq_q [2][QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    side_t         s_in;
    logic [WW-1:0] w_in;

    if (k == 0) begin : g_head
      assign s_in = sd2_q;
      assign w_in = w2_q;
    end else begin : g_body
      assign s_in = dv_q[k-1];
      assign w_in = dw_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= '0;
      end else if (adv) begin
        dv_q[k] <= s_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dw_q[k] <= w_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [WW-1:0] tr;
      logic [QW-1:0] q_in;
      logic          ge;

      if (k == 0) begin : g_head
        assign tr   = num2_q[l];
        assign q_in = '0;
      end else begin : g_body
        assign tr   = {dr_q[l][k-1][WW-2:0], 1'b0};
        assign q_in = dq_q[l][k-1];
      end

      assign ge = tr >= w_in;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dr_q[l][k] <= ge ? (tr - w_in) : tr;
          dq_q[l][k] <= {q_in[QW-2:0], ge};
        end
      end
    end
  end

  // Square root of each ratio gives |u| / sqrt(W) in Q.31.
  logic [CW-1:0] c_w [2];
  side_t         sq_q [CW];

  for (genvar l = 0; l < 2; l++) begin : g_croot
    pgsg_isqrt_pipe #(
      .RW (CW)
    ) u_croot (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  ((2*CW)'(dq_q[l][QW-1])),
      .root_o (c_w[l])
    );
  end

  // Control bits ride alongside the root stages.
  for (genvar j = 0; j < CW; j++) begin : g_cside
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[j] <= '0;
      end else if (adv) begin
        sq_q[j] <= (j == 0) ? dv_q[QW-1] : sq_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Normalise W by a binary leading-zero search.
  logic [WW-1:0]  nz_q [LZB];
  logic [LZB-1:0] lz_q [LZB];

  for (genvar j = 0; j < LZB; j++) begin : g_norm
    localparam int SH = 1 << (LZB - 1 - j);
    logic [WW-1:0]  n_in;
    logic [LZB-1:0] l_in;
    logic           zero;

    if (j == 0) begin : g_head
      assign n_in = w2_q;
      assign l_in = '0;
    end else begin : g_body
      assign n_in = nz_q[j-1];
      assign l_in = lz_q[j-1];
    end

    assign zero = ~|n_in[WW-1 -: SH];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        nz_q[j] <= zero ? (n_in << SH) : n_in;
        lz_q[j] <= zero ? (l_in | LZB'(SH)) : l_in;
      end
    end
  end

  // Mantissa in [1,2) as Q.30, truncated.
  logic [WW+XW-1:0] xext;
  logic [XW-1:0]    x0;

  assign xext = {nz_q[LZB-1], {XW{1'b0}}};
  assign x0   = xext[WW+XW-1 -: XW];

  // Fraction of log2 by repeated squaring, one bit per stage.
  logic [XW-1:0]         x_q   [LOG_ROUNDS];
  logic [LOG_ROUNDS-1:0] fr_q  [LOG_ROUNDS];
  logic [LZB-1:0]        lzs_q [LOG_ROUNDS];

  for (genvar i = 0; i < LOG_ROUNDS; i++) begin : g_log
    logic [XW-1:0]         x_in;
    logic [LOG_ROUNDS-1:0] f_in;
    logic [LZB-1:0]        z_in;
    logic [2*XW-1:0]       prod;
    logic [XW:0]           t;

    if (i == 0) begin : g_head
      assign x_in = x0;
      assign f_in = '0;
      assign z_in = lz_q[LZB-1];
    end else begin : g_body
      assign x_in = x_q[i-1];
      assign f_in = fr_q[i-1];
      assign z_in = lzs_q[i-1];
    end

    assign prod = x_in * x_in;
    assign t    = prod[2*XW-1 -: XW+1];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[i]   <= t[XW] ? t[XW:1] : t[XW-1:0];
        fr_q[i]  <= {f_in[LOG_ROUNDS-2:0], t[XW]};
        lzs_q[i] <= z_in;
      end
    end
  end

  // -log2 W in Q.24, then -2 ln W in Q.54.
  logic [LW-1:0] l_q;
  logic [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q <= {lzs_q[LOG_ROUNDS-1] - 1'b1, {LOG_ROUNDS{1'b0}}} - LW'(fr_q[LOG_ROUNDS-1]);
      p_q <= PW'(l_q) * PW'(TWO_LN2_Q30);
    end
  end

  // sqrt(-2 ln W) in Q.27, delayed to meet the ratio roots.
  logic [GW-1:0] g_w;
  logic [GW-1:0] gd_q [GDLY];

  pgsg_isqrt_pipe #(
    .RW (GW)
  ) u_groot (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ((2*GW)'(p_q)),
    .root_o (g_w)
  );

  for (genvar j = 0; j < GDLY; j++) begin : g_gdly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        gd_q[j] <= (j == 0) ? g_w : gd_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Deviate magnitude, scaled deviate, then mean and saturation.
  side_t                      m1_q;
  side_t                      m2_q;
  side_t                      t_q;
  logic [DW-1:0]              d_q  [2];
  logic [DEVW-1:0]            e_q  [2];
  logic signed [SAMPLE_W-1:0] ts_q [2];
  logic                       tc_q [2];
  logic [DPW-1:0]             dsum [2];
  logic [EPW-1:0]             esum [2];
  logic signed [SUMW-1:0]     ssum [2];
  logic                       sovf [2];
  logic [1:0]                 m2_neg;

  assign m2_neg = {m2_q.neg_b, m2_q.neg_a};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dsum[l] = DPW'(c_w[l]) * DPW'(gd_q[GDLY-1]) + D_RND;
      esum[l] = EPW'(d_q[l]) * EPW'(scale_q) + E_RND;
      ssum[l] = m2_neg[l] ? (SUMW'(mean_q) - SUMW'($signed({1'b0, e_q[l]})))
                          : (SUMW'(mean_q) + SUMW'($signed({1'b0, e_q[l]})));
      sovf[l] = !((&ssum[l][SUMW-1:SAMPLE_W-1]) || (~|ssum[l][SUMW-1:SAMPLE_W-1]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      t_q  <= '0;
    end else if (adv) begin
      m1_q <= sq_q[CW-1];
      m2_q <= m1_q;
      t_q  <= m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        d_q[l]  <= dsum[l][DPW-1 -: DW];
        e_q[l]  <= esum[l][EPW-1 -: DEVW];
        ts_q[l] <= sovf[l] ? (ssum[l][SUMW-1] ? SAMPLE_MIN : SAMPLE_MAX)
                           : ssum[l][SAMPLE_W-1:0];
        tc_q[l] <= sovf[l];
      end
    end
  end

  // Pair buffer: hands out the first and then the second sample.
  logic                       pv_q;
  logic                       sec_q;
  logic signed [SAMPLE_W-1:0] ps_q [2];
  logic                       pc_q [2];
  logic                       tail_live;
  logic                       pair_free;
  logic                       pair_load;

  assign tail_live = t_q.valid && t_q.ok;
  assign pair_free = !pv_q || (sec_q && out_o.ready);
  assign pair_load = tail_live && pair_free;
  assign adv       = !tail_live || pair_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      sec_q <= 1'b0;
    end else if (pair_load) begin
      pv_q  <= 1'b1;
      sec_q <= 1'b0;
    end else if (pv_q && out_o.ready) begin
      pv_q  <= !sec_q;
      sec_q <= !sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_load) begin
      ps_q <= ts_q;
      pc_q <= tc_q;
    end
  end

  assign in_i.ready          = adv;
  assign out_o.valid         = pv_q;
  assign out_o.normal_sample = sec_q ? ps_q[1] : ps_q[0];
  assign out_o.last_of_pair  = sec_q;
  assign out_o.clipped       = sec_q ? pc_q[1] : pc_q[0];

  // Checks on the pair buffer and the tail of the pipeline.
  `PGSG_ASSERT_NEXT(a_second_follows, out_o.valid && out_o.ready && !out_o.last_of_pair, out_o.valid && out_o.last_of_pair, "second sample of a pair did not follow the first")
  `PGSG_ASSERT_NEXT(a_reject_dropped, t_q.valid && !t_q.ok && !pv_q, !pv_q, "a rejected pair reached the output")
  `PGSG_ASSERT_NEXT(a_pair_ends, out_o.valid && out_o.ready && out_o.last_of_pair && !tail_live, !out_o.valid, "output stayed valid after the last sample of a pair")
  `PGSG_ASSERT_NEXT(a_tail_holds, tail_live && !adv, t_q.valid && $stable(ts_q[0]) && $stable(ts_q[1]), "stalled tail item changed")
  `PGSG_ASSERT_SAME(a_busy_stalls, tail_live && pv_q && !sec_q, !in_i.ready, "input taken while the pair buffer was full")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import pgsg_pkg::*;

  localparam int UBITS     = 16;
  localparam int FBITS     = UBITS - 1;
  localparam int MAX_CYC   = 600000;
  localparam int PIPE_WAIT = 200;

  // One expected output beat.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       clip;
  } gauss_beat_t;

  // Computes the samples of each accepted pair and checks the output beats against them.
  class gauss_board;
    logic signed [SAMPLE_W-1:0] mean;
    logic [SCALE_W-1:0]         scale;
    gauss_beat_t                pending_q[$];
    int unsigned                errors, pairs, dropped, samples, clips;

    function new();
      mean  = '0;
      scale = STD_SCALE_RESET;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Quotient num / den with 62 fraction bits, num <= den.
    function longint unsigned ratio62(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (r >= den) begin
        q = 1;
        r = r - den;
      end
      for (int i = 0; i < 62; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    // Minus log2 of W, Q.24, by repeated squaring of the normalised mantissa.
    function longint unsigned minus_log2(longint unsigned w);
      int              n;
      longint unsigned x, frac;
      n    = 0;
      frac = 0;
      while (n < 63 && (w >> (n + 1)) != 0) n++;
      x = (n >= 30) ? (w >> (n - 30)) : (w << (30 - n));
      for (int i = 0; i < 24; i++) begin
        x    = (x * x) >> 30;
        frac = frac << 1;
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(2 * FBITS - n) << 24) - frac;
    endfunction

    function gauss_beat_t one_sample(logic neg, longint unsigned mag, longint unsigned w,
                                     longint unsigned g, logic last);
      longint unsigned c, d, dev;
      longint          s;
      gauss_beat_t     b;
      c   = int_sqrt(ratio62(mag * mag, w));
      d   = (c * g + (64'd1 << 29)) >> 30;
      dev = (d * longint'(scale) + (64'd1 << 23)) >> 24;
      s   = neg ? longint'(mean) - longint'(dev) : longint'(mean) + longint'(dev);
      b.last = last;
      b.clip = 1'b0;
      if (s > longint'(SAMPLE_MAX)) begin
        s      = longint'(SAMPLE_MAX);
        b.clip = 1'b1;
      end else if (s < longint'(SAMPLE_MIN)) begin
        s      = longint'(SAMPLE_MIN);
        b.clip = 1'b1;
      end
      b.sample = s[SAMPLE_W-1:0];
      return b;
    endfunction

    // Note an accepted input beat and queue the samples it gives, if any.
    function void note_pair(logic [UBITS-1:0] ua, logic [UBITS-1:0] ub);
      longint unsigned ma, mb, w, g;
      gauss_beat_t     b;
      pairs++;
      ma = ua[UBITS-1] ? (64'd1 << UBITS) - ua : ua;
      mb = ub[UBITS-1] ? (64'd1 << UBITS) - ub : ub;
      w  = ma * ma + mb * mb;
      if (w == 0 || w >= (64'd1 << (2 * FBITS))) begin
        dropped++;
        return;
      end
      g = int_sqrt(minus_log2(w) * longint'(TWO_LN2_Q30));
      b = one_sample(ua[UBITS-1], ma, w, g, 1'b0);
      clips += b.clip;
      pending_q.push_back(b);
      b = one_sample(ub[UBITS-1], mb, w, g, 1'b1);
      clips += b.clip;
      pending_q.push_back(b);
    endfunction

    function void check_beat(logic signed [SAMPLE_W-1:0] smp, logic last, logic clip);
      gauss_beat_t b;
      samples++;
      if (pending_q.size() == 0) begin
        $error("unexpected sample %0d", smp);
        errors++;
        return;
      end
      b = pending_q.pop_front();
      if (smp !== b.sample) begin
        $error("normal_sample: expected %0d, got %0d", b.sample, smp);
        errors++;
      end
      if (last !== b.last) begin
        $error("last_of_pair: expected %0b, got %0b", b.last, last);
        errors++;
      end
      if (clip !== b.clip) begin
        $error("clipped: expected %0b, got %0b", b.clip, clip);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  pgsg_in_if #(.UNIFORM_BITS(UBITS)) in_if ();
  pgsg_out_if                        out_if ();

  polar_gaussian_sample_generator #(.UNIFORM_BITS(UBITS)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  gauss_board  board = new();
  int unsigned send_idle_pct, recv_stall_pct, cyc_count;
  bit          hold_off;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls at random, or for a whole stretch while held off.
  always @(posedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted output beat is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_beat(out_if.normal_sample, out_if.last_of_pair, out_if.clipped);
    end
  end

  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > MAX_CYC) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MEAN_OFFSET) board.mean = val;
    else board.scale = val[SCALE_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic send_pair(logic [UBITS-1:0] ua, logic [UBITS-1:0] ub);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.uniform_first  <= ua;
    in_if.uniform_second <= ub;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_pair(ua, ub);
  endtask

  // Lets the pipeline empty; dropped pairs give no sign, so a fixed wait follows.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_WAIT) @(posedge clk_i);
  endtask

  // Random values, about one in four of them scaled down by a random arithmetic shift.
  function automatic logic [UBITS-1:0] rand_uniform();
    logic [UBITS-1:0] v;
    v = UBITS'($urandom);
    if ($urandom_range(3) == 0) v = UBITS'($signed(v) >>> $urandom_range(14));
    return v;
  endfunction

  task automatic random_pairs(int cnt);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) send_pair(rand_uniform(), '0);
      else send_pair(rand_uniform(), rand_uniform());
    end
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  initial begin
    in_if.valid          = 1'b0;
    in_if.uniform_first  = '0;
    in_if.uniform_second = '0;
    set_idling(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs under the reset settings: zero, minus one, edges of the circle.
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h0000);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h0000);
    send_pair(16'h0000, 16'h7FFF);
    send_pair(16'h8001, 16'h0000);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h5A82, 16'h5A82);
    send_pair(16'hA57E, 16'h5A81);
    send_pair(16'h4000, 16'hC000);
    send_pair(16'h7FFF, 16'hFFFF);
    send_pair(16'h0100, 16'hFF00);
    random_pairs(230);
    drain();

    // Largest mean and scale, so positive samples clip.
    write_reg(CFG_MEAN_OFFSET, 32'h7FFF_FFFF);
    write_reg(CFG_STD_SCALE, 16'hFFFF);
    set_idling(1);
    send_pair(16'h7FFF, 16'h0001);
    send_pair(16'h8001, 16'h0001);
    random_pairs(230);
    drain();

    // Smallest mean, and a long hold-off on the receiver so the input stalls.
    write_reg(CFG_MEAN_OFFSET, 32'h8000_0000);
    set_idling(2);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    send_pair(16'h8001, 16'h0001);
    random_pairs(240);
    drain();

    // Zero scale: every sample equals the mean.
    write_reg(CFG_MEAN_OFFSET, 32'h0000_0000);
    write_reg(CFG_STD_SCALE, 16'h0000);
    set_idling(3);
    random_pairs(240);
    drain();

    // Random settings, with a pause midway until every sample has come.
    write_reg(CFG_MEAN_OFFSET, $urandom);
    write_reg(CFG_STD_SCALE, 16'($urandom));
    set_idling(0);
    random_pairs(120);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    random_pairs(120);
    drain();

    write_reg(CFG_MEAN_OFFSET, 32'hFFFF_0000);
    write_reg(CFG_STD_SCALE, 16'h1000);
    set_idling(3);
    random_pairs(240);
    drain();

    if (board.pending_q.size() != 0) begin
      $error("%0d samples never arrived", board.pending_q.size());
      board.errors++;
    end
    $display("Sent %0d uniform pairs (%0d rejected), checked %0d samples, %0d clipped.",
             board.pairs, board.dropped, board.samples, board.clips);
    $display("Six register settings, four idling mixes, one long output hold-off.");
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
